>>> design/tlr_pkg.sv
package tlr_pkg;

  localparam int CoordBits  = 12;
  localparam int OutBits    = CoordBits + 1;
  localparam int ColorBits  = 24;
  localparam int RadBits    = 3;
  localparam int BrushBits  = 4;
  localparam int ErrBits    = CoordBits + 2;
  localparam int RegBits    = 12;
  localparam int CfgIdxBits = 1;

  localparam logic [RadBits-1:0] MaxRadius = RadBits'(7);

  localparam logic [RegBits-1:0] ImageSizeReset = RegBits'(2048);

  localparam logic [CfgIdxBits-1:0] CfgImageWidth  = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgImageHeight = CfgIdxBits'(1);

  localparam logic CmdStart = 1'b0;
  localparam logic CmdTick  = 1'b1;

endpackage

>>> design/thick_line_rasterizer_core.sv
// Bresenham line rasterizer with a square brush. A start request (cmd 0) loads
// both endpoints, the color and the brush radius and returns an empty result
// (pixel_valid low, all fields zero). A tick (cmd 1) on an active line returns
// one pixel: the brush is walked row by row around the current line point,
// then the line either ends (last high) or takes one Bresenham step. Pixels
// outside image_width by image_height are returned with write_enable low; a
// size register of zero means 4096. Every request returns exactly one result
// in the cycle after it is taken, through a single output register; the block
// takes one request per clock while that register is empty or being drained.
// The image size registers may only be written while no result is pending.
module thick_line_rasterizer_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tlr_pkg::CfgIdxBits-1:0]        cfg_index_i,
  input  logic [tlr_pkg::RegBits-1:0]           cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  cmd_i,
  input  logic signed [tlr_pkg::CoordBits-1:0]  start_x_i,
  input  logic signed [tlr_pkg::CoordBits-1:0]  start_y_i,
  input  logic signed [tlr_pkg::CoordBits-1:0]  end_x_i,
  input  logic signed [tlr_pkg::CoordBits-1:0]  end_y_i,
  input  logic [tlr_pkg::ColorBits-1:0]         line_color_i,
  input  logic [tlr_pkg::RadBits-1:0]           brush_radius_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [tlr_pkg::OutBits-1:0]    pixel_x_o,
  output logic signed [tlr_pkg::OutBits-1:0]    pixel_y_o,
  output logic [tlr_pkg::ColorBits-1:0]         pixel_color_o,
  output logic                                  write_enable_o,
  output logic                                  pixel_valid_o,
  output logic                                  last_o
);

  localparam int CB = tlr_pkg::CoordBits;
  localparam int OB = tlr_pkg::OutBits;
  localparam int EB = tlr_pkg::ErrBits;
  localparam int BB = tlr_pkg::BrushBits;
  localparam int RB = tlr_pkg::RadBits;

  logic [tlr_pkg::RegBits-1:0] width_q, height_q;
  logic                        active_q, active_d;
  logic signed [CB-1:0]        pt_x_q, pt_x_d, pt_y_q, pt_y_d;
  logic signed [CB-1:0]        tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [CB-1:0]               dlt_x_q, dlt_x_d, dlt_y_q, dlt_y_d;
  logic                        neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic signed [EB-1:0]        err_q, err_d;
  logic signed [BB-1:0]        bdx_q, bdx_d, bdy_q, bdy_d;
  logic [RB-1:0]               rad_q, rad_d;
  logic [tlr_pkg::ColorBits-1:0] col_q, col_d;

  logic                        out_valid_q;
  logic signed [OB-1:0]        px_q, px_d, py_q, py_d;
  logic [tlr_pkg::ColorBits-1:0] ocol_q, ocol_d;
  logic                        we_q, we_d, pv_q, pv_d, last_q, last_d;

  logic                        take;
  logic [RB-1:0]               rad_in;
  logic signed [OB-1:0]        px, py;
  logic [OB-1:0]               size_w, size_h;
  logic signed [BB:0]          bdx_inc, bdy_inc, rad_s;
  logic signed [EB:0]          e2;
  logic                        step_x, step_y;
  logic                        at_end;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  assign rad_in  = (brush_radius_i > tlr_pkg::MaxRadius) ? tlr_pkg::MaxRadius : brush_radius_i;
  assign px      = OB'(pt_x_q) + OB'(bdx_q);
  assign py      = OB'(pt_y_q) + OB'(bdy_q);
  assign size_w  = {width_q == '0, width_q};
  assign size_h  = {height_q == '0, height_q};
  assign bdx_inc = (BB+1)'(bdx_q) + (BB+1)'(1);
  assign bdy_inc = (BB+1)'(bdy_q) + (BB+1)'(1);
  assign rad_s   = $signed({{(BB+1-RB){1'b0}}, rad_q});
  assign e2      = {err_q, 1'b0};
  assign step_x  = e2 > -$signed({{(EB+1-CB){1'b0}}, dlt_y_q});
  assign step_y  = e2 < $signed({{(EB+1-CB){1'b0}}, dlt_x_q});
  assign at_end  = (pt_x_q == tgt_x_q) && (pt_y_q == tgt_y_q);

  always_comb begin
    active_d = active_q;
    pt_x_d   = pt_x_q;
    pt_y_d   = pt_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    dlt_x_d  = dlt_x_q;
    dlt_y_d  = dlt_y_q;
    neg_x_d  = neg_x_q;
    neg_y_d  = neg_y_q;
    err_d    = err_q;
    bdx_d    = bdx_q;
    bdy_d    = bdy_q;
    rad_d    = rad_q;
    col_d    = col_q;
    px_d     = '0;
    py_d     = '0;
    ocol_d   = '0;
    we_d     = 1'b0;
    pv_d     = 1'b0;
    last_d   = 1'b0;
    if (cmd_i == tlr_pkg::CmdStart) begin
      active_d = 1'b1;
      pt_x_d   = start_x_i;
      pt_y_d   = start_y_i;
      tgt_x_d  = end_x_i;
      tgt_y_d  = end_y_i;
      dlt_x_d  = (end_x_i > start_x_i) ? CB'(end_x_i - start_x_i) : CB'(start_x_i - end_x_i);
      dlt_y_d  = (end_y_i > start_y_i) ? CB'(end_y_i - start_y_i) : CB'(start_y_i - end_y_i);
      neg_x_d  = !(start_x_i < end_x_i);
      neg_y_d  = !(start_y_i < end_y_i);
      err_d    = $signed(EB'(dlt_x_d)) - $signed(EB'(dlt_y_d));
      rad_d    = rad_in;
      bdx_d    = -$signed(BB'(rad_in));
      bdy_d    = -$signed(BB'(rad_in));
      col_d    = line_color_i;
    end else if (active_q) begin
      px_d   = px;
      py_d   = py;
      ocol_d = col_q;
      pv_d   = 1'b1;
      we_d   = !px[OB-1] && !py[OB-1] && ($unsigned(px) < size_w) && ($unsigned(py) < size_h);
      if (bdx_inc > rad_s) begin
        bdx_d = -$signed(BB'(rad_q));
        if (bdy_inc > rad_s) begin
          bdy_d = -$signed(BB'(rad_q));
          if (at_end) begin
            last_d   = 1'b1;
            active_d = 1'b0;
          end else begin
            err_d = err_q - (step_x ? $signed(EB'(dlt_y_q)) : '0)
                          + (step_y ? $signed(EB'(dlt_x_q)) : '0);
            if (step_x) begin
              pt_x_d = neg_x_q ? pt_x_q - CB'(1) : pt_x_q + CB'(1);
            end
            if (step_y) begin
              pt_y_d = neg_y_q ? pt_y_q - CB'(1) : pt_y_q + CB'(1);
            end
          end
        end else begin
          bdy_d = BB'(bdy_inc);
        end
      end else begin
        bdx_d = BB'(bdx_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tlr_pkg::ImageSizeReset;
      height_q <= tlr_pkg::ImageSizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tlr_pkg::CfgImageWidth:  width_q  <= cfg_data_i;
        tlr_pkg::CfgImageHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pt_x_q   <= '0;
      pt_y_q   <= '0;
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      dlt_x_q  <= '0;
      dlt_y_q  <= '0;
      neg_x_q  <= 1'b0;
      neg_y_q  <= 1'b0;
      err_q    <= '0;
      bdx_q    <= '0;
      bdy_q    <= '0;
      rad_q    <= '0;
      col_q    <= '0;
    end else if (take) begin
      active_q <= active_d;
      pt_x_q   <= pt_x_d;
      pt_y_q   <= pt_y_d;
      tgt_x_q  <= tgt_x_d;
      tgt_y_q  <= tgt_y_d;
      dlt_x_q  <= dlt_x_d;
      dlt_y_q  <= dlt_y_d;
      neg_x_q  <= neg_x_d;
      neg_y_q  <= neg_y_d;
      err_q    <= err_d;
      bdx_q    <= bdx_d;
      bdy_q    <= bdy_d;
      rad_q    <= rad_d;
      col_q    <= col_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      px_q   <= px_d;
      py_q   <= py_d;
      ocol_q <= ocol_d;
      we_q   <= we_d;
      pv_q   <= pv_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign pixel_color_o  = ocol_q;
  assign write_enable_o = we_q;
  assign pixel_valid_o  = pv_q;
  assign last_o         = last_q;

endmodule

>>> design/tlr_checker.sv
module tlr_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_o,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic signed [tlr_pkg::OutBits-1:0]    pixel_x_o,
  input logic signed [tlr_pkg::OutBits-1:0]    pixel_y_o,
  input logic [tlr_pkg::ColorBits-1:0]         pixel_color_o,
  input logic                                  write_enable_o,
  input logic                                  pixel_valid_o,
  input logic                                  last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_x_o) &&
      $stable(pixel_y_o) && $stable(pixel_color_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("not ready with empty output register");

  a_take_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request gave no result");

  a_write_needs_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (write_enable_o || last_o) |-> pixel_valid_o)
    else $error("write or last without pixel");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pixel_valid_o |->
      pixel_x_o == '0 && pixel_y_o == '0 && pixel_color_o == '0)
    else $error("empty result with nonzero fields");

endmodule

bind thick_line_rasterizer_core tlr_checker u_tlr_checker (.*);
